### rtl/core/uoeu_pkg.sv
// uoeu_pkg: shared types for the undocumented opcode execute unit
// decoded operation codes and the item carried from front to back
// no dependencies
package uoeu_pkg;

   localparam logic [7:0] SP_RESET = 8'hFD;
   localparam logic [2:0] COL_IMM  = 3'd2;
   localparam logic [2:0] COL_ABSY = 3'd6;
   localparam logic [2:0] COL_INDY = 3'd4;
   localparam logic [2:0] COL_ABSX = 3'd7;
   localparam logic [2:0] ROW_SLO  = 3'd0;
   localparam logic [2:0] ROW_RLA  = 3'd1;
   localparam logic [2:0] ROW_SRE  = 3'd2;
   localparam logic [2:0] ROW_RRA  = 3'd3;
   localparam logic [2:0] ROW_SAX  = 3'd4;
   localparam logic [2:0] ROW_LAX  = 3'd5;
   localparam logic [2:0] ROW_DCP  = 3'd6;
   localparam logic [2:0] ROW_ISC  = 3'd7;

   typedef enum logic [4:0] {
      OP_SLO, OP_RLA, OP_SRE, OP_RRA, OP_ANC, OP_ALR, OP_ARR, OP_SAX, OP_TAS,
      OP_AHX, OP_XAA, OP_LAX, OP_LAS, OP_AXS, OP_DCP, OP_ISC, OP_SBC
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] operand;
      logic [7:0] addr_hi_inc;
   } item_type;

endpackage

### rtl/core/uoeu_front.sv
// uoeu_front: accepts request beats and decodes row and column into an operation
// depends on uoeu_pkg
module uoeu_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [2:0]          req_operation,
   input  logic [2:0]          req_column,
   input  logic [7:0]          req_operand,
   input  logic [7:0]          req_address_high,
   output logic                push_valid,
   input  logic                push_stall,
   output uoeu_pkg::item_type  push_item
);

   logic               valid_ff, valid_in;
   uoeu_pkg::item_type item_ff, item_in;
   uoeu_pkg::op_type   op;
   logic               imm;
   logic               accept;

   assign imm = (req_column == uoeu_pkg::COL_IMM);

   always_comb begin
      unique case (req_operation)
         uoeu_pkg::ROW_SLO: op = imm ? uoeu_pkg::OP_ANC : uoeu_pkg::OP_SLO;
         uoeu_pkg::ROW_RLA: op = imm ? uoeu_pkg::OP_ANC : uoeu_pkg::OP_RLA;
         uoeu_pkg::ROW_SRE: op = imm ? uoeu_pkg::OP_ALR : uoeu_pkg::OP_SRE;
         uoeu_pkg::ROW_RRA: op = imm ? uoeu_pkg::OP_ARR : uoeu_pkg::OP_RRA;
         uoeu_pkg::ROW_SAX: begin
            if (imm)
               op = uoeu_pkg::OP_XAA;
            else if (req_column == uoeu_pkg::COL_ABSY)
               op = uoeu_pkg::OP_TAS;
            else if (req_column inside {uoeu_pkg::COL_INDY, uoeu_pkg::COL_ABSX})
               op = uoeu_pkg::OP_AHX;
            else
               op = uoeu_pkg::OP_SAX;
         end
         uoeu_pkg::ROW_LAX: op = (req_column == uoeu_pkg::COL_ABSY) ?
                                 uoeu_pkg::OP_LAS : uoeu_pkg::OP_LAX;
         uoeu_pkg::ROW_DCP: op = imm ? uoeu_pkg::OP_AXS : uoeu_pkg::OP_DCP;
         default:           op = imm ? uoeu_pkg::OP_SBC : uoeu_pkg::OP_ISC;
      endcase
   end

   assign req_stall = valid_ff && push_stall;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff && push_stall;
      item_in  = item_ff;
      if (accept) begin
         valid_in            = 1'b1;
         item_in.op          = op;
         item_in.operand     = req_operand;
         item_in.addr_hi_inc = req_address_high + 8'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign push_valid = valid_ff;
   assign push_item  = item_ff;

endmodule

### rtl/core/uoeu_queue.sv
// uoeu_queue: two-entry queue between decode and execute
// depends on uoeu_pkg
module uoeu_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_stall,
   input  uoeu_pkg::item_type  push_item,
   output logic                pop_valid,
   input  logic                pop_stall,
   output uoeu_pkg::item_type  pop_item
);

   uoeu_pkg::item_type entry_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff, count_in;
   logic               push, pop;

   assign push_stall = (count_ff == 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && !push_stall;
   assign pop        = pop_valid && !pop_stall;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### rtl/core/uoeu_back.sv
// uoeu_back: executes decoded operations against A, X, SP and flags
// holds the response register; depends on uoeu_pkg
module uoeu_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   output logic                pop_stall,
   input  uoeu_pkg::item_type  pop_item,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_write_enable,
   output logic [7:0]          rsp_write_data,
   output logic [7:0]          rsp_acc_out,
   output logic [7:0]          rsp_index_x_out,
   output logic [7:0]          rsp_stack_ptr_out,
   output logic                rsp_carry_out,
   output logic                rsp_zero_out,
   output logic                rsp_negative_out,
   output logic                rsp_overflow_out
);

   logic [7:0] a_ff, a_in, x_ff, x_in, sp_ff, sp_in;
   logic       c_ff, c_in, z_ff, z_in, n_ff, n_in, v_ff, v_in;
   logic       out_valid_ff, out_valid_in;
   logic       wen_ff, wen_in;
   logic [7:0] wdata_ff, wdata_in;
   logic       take;

   logic [7:0] m, hp, t, zn_val, sub_opnd, wd_dec;
   logic [8:0] sum, diff;
   logic       cin, borrow;

   assign pop_stall = out_valid_ff && rsp_stall;
   assign take      = pop_valid && !pop_stall;
   assign m         = pop_item.operand;
   assign hp        = pop_item.addr_hi_inc;
   assign wd_dec    = m - 8'd1;

   always_comb begin
      a_in     = a_ff;
      x_in     = x_ff;
      sp_in    = sp_ff;
      c_in     = c_ff;
      v_in     = v_ff;
      wen_in   = 1'b0;
      wdata_in = 8'd0;
      t        = a_ff & x_ff;
      zn_val   = a_ff;
      cin      = c_ff;
      sum      = 9'd0;
      diff     = 9'd0;
      borrow   = !c_ff;
      sub_opnd = m;
      unique case (pop_item.op)
         uoeu_pkg::OP_ANC: begin
            a_in   = a_ff & m;
            zn_val = a_in;
            c_in   = a_in[7];
         end
         uoeu_pkg::OP_SLO: begin
            wen_in   = 1'b1;
            wdata_in = {m[6:0], 1'b0};
            c_in     = m[7];
            a_in     = a_ff | wdata_in;
            zn_val   = a_in;
         end
         uoeu_pkg::OP_RLA: begin
            wen_in   = 1'b1;
            wdata_in = {m[6:0], c_ff};
            c_in     = m[7];
            a_in     = a_ff & wdata_in;
            zn_val   = a_in;
         end
         uoeu_pkg::OP_SRE: begin
            wen_in   = 1'b1;
            wdata_in = {1'b0, m[7:1]};
            c_in     = m[0];
            a_in     = a_ff ^ wdata_in;
            zn_val   = a_in;
         end
         uoeu_pkg::OP_ALR: begin
            t      = a_ff & m;
            c_in   = t[0];
            a_in   = {1'b0, t[7:1]};
            zn_val = a_in;
         end
         uoeu_pkg::OP_ARR: begin
            t      = a_ff & m;
            a_in   = {c_ff, t[7:1]};
            zn_val = a_in;
            c_in   = a_in[6];
            v_in   = a_in[6] ^ a_in[5];
         end
         uoeu_pkg::OP_RRA: begin
            wen_in   = 1'b1;
            wdata_in = {c_ff, m[7:1]};
            cin      = m[0];
            sum      = {1'b0, a_ff} + {1'b0, wdata_in} + {8'd0, cin};
            v_in     = (~(a_ff[7] ^ wdata_in[7])) & (a_ff[7] ^ sum[7]);
            c_in     = sum[8];
            a_in     = sum[7:0];
            zn_val   = a_in;
         end
         uoeu_pkg::OP_SAX: begin
            wen_in   = 1'b1;
            wdata_in = t;
            zn_val   = a_ff;
         end
         uoeu_pkg::OP_TAS: begin
            sp_in    = t;
            wen_in   = 1'b1;
            wdata_in = t & hp;
         end
         uoeu_pkg::OP_AHX: begin
            wen_in   = 1'b1;
            wdata_in = t & hp;
         end
         uoeu_pkg::OP_XAA: begin
            a_in   = x_ff & m;
            zn_val = a_in;
         end
         uoeu_pkg::OP_LAX: begin
            a_in   = m;
            x_in   = m;
            zn_val = m;
         end
         uoeu_pkg::OP_LAS: begin
            t      = m & sp_ff;
            a_in   = t;
            x_in   = t;
            sp_in  = t;
            zn_val = t;
         end
         uoeu_pkg::OP_AXS: begin
            diff   = {1'b0, t} - {1'b0, m};
            c_in   = !diff[8];
            x_in   = diff[7:0];
            zn_val = x_in;
         end
         uoeu_pkg::OP_DCP: begin
            wen_in   = 1'b1;
            wdata_in = wd_dec;
            diff     = {1'b0, a_ff} - {1'b0, wd_dec};
            c_in     = !diff[8];
            zn_val   = diff[7:0];
         end
         default: begin
            if (pop_item.op == uoeu_pkg::OP_ISC) begin
               wen_in   = 1'b1;
               wdata_in = m + 8'd1;
               sub_opnd = wdata_in;
            end
            diff   = {1'b0, a_ff} - {1'b0, sub_opnd} - {8'd0, borrow};
            c_in   = !diff[8];
            v_in   = (a_ff[7] ^ diff[7]) & (a_ff[7] ^ sub_opnd[7]);
            a_in   = diff[7:0];
            zn_val = a_in;
         end
      endcase
      z_in = (zn_val == 8'd0);
      n_in = zn_val[7];
      if (pop_item.op inside {uoeu_pkg::OP_SAX, uoeu_pkg::OP_TAS, uoeu_pkg::OP_AHX}) begin
         z_in = z_ff;
         n_in = n_ff;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff && rsp_stall;
      if (take) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         a_ff         <= 8'd0;
         x_ff         <= 8'd0;
         sp_ff        <= uoeu_pkg::SP_RESET;
         c_ff         <= 1'b0;
         z_ff         <= 1'b0;
         n_ff         <= 1'b0;
         v_ff         <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (take) begin
            a_ff  <= a_in;
            x_ff  <= x_in;
            sp_ff <= sp_in;
            c_ff  <= c_in;
            z_ff  <= z_in;
            n_ff  <= n_in;
            v_ff  <= v_in;
         end
      end
      if (take) begin
         wen_ff   <= wen_in;
         wdata_ff <= wdata_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_write_enable  = wen_ff;
   assign rsp_write_data    = wdata_ff;
   assign rsp_acc_out       = a_ff;
   assign rsp_index_x_out   = x_ff;
   assign rsp_stack_ptr_out = sp_ff;
   assign rsp_carry_out     = c_ff;
   assign rsp_zero_out      = z_ff;
   assign rsp_negative_out  = n_ff;
   assign rsp_overflow_out  = v_ff;

endmodule

### rtl/core/undocumented_opcode_execute_unit.sv
// undocumented_opcode_execute_unit: top level of the undocumented opcode executor
// ties decode front, queue and execute back; depends on uoeu_pkg and uoeu_* modules
//
//   channel | direction | handshake            | beat contents
//   req     | in        | req_valid/req_stall  | operation, column, operand, address_high
//   rsp     | out       | rsp_valid/rsp_stall  | write enable/data, A, X, SP, C, Z, N, V
//
// one beat per cycle sustained while rsp_stall is low; rsp_valid rises once the beat has passed
// the decode register, the queue entry and the response register, in that order
// reset clears A, X and the flags and sets SP to 0xFD; queue and response go empty
// rsp_stall holds the response register; the queue and decode register absorb three
// more beats before req_stall rises
module undocumented_opcode_execute_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_operation,
   input  logic [2:0] req_column,
   input  logic [7:0] req_operand,
   input  logic [7:0] req_address_high,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_write_enable,
   output logic [7:0] rsp_write_data,
   output logic [7:0] rsp_acc_out,
   output logic [7:0] rsp_index_x_out,
   output logic [7:0] rsp_stack_ptr_out,
   output logic       rsp_carry_out,
   output logic       rsp_zero_out,
   output logic       rsp_negative_out,
   output logic       rsp_overflow_out
);

   logic               push_valid, push_stall;
   uoeu_pkg::item_type push_item;
   logic               pop_valid, pop_stall;
   uoeu_pkg::item_type pop_item;

   uoeu_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_column       (req_column),
      .req_operand      (req_operand),
      .req_address_high (req_address_high),
      .push_valid       (push_valid),
      .push_stall       (push_stall),
      .push_item        (push_item)
   );

   uoeu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_stall (push_stall),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_stall  (pop_stall),
      .pop_item   (pop_item)
   );

   uoeu_back u_back (
      .clock             (clock),
      .reset             (reset),
      .pop_valid         (pop_valid),
      .pop_stall         (pop_stall),
      .pop_item          (pop_item),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_write_enable  (rsp_write_enable),
      .rsp_write_data    (rsp_write_data),
      .rsp_acc_out       (rsp_acc_out),
      .rsp_index_x_out   (rsp_index_x_out),
      .rsp_stack_ptr_out (rsp_stack_ptr_out),
      .rsp_carry_out     (rsp_carry_out),
      .rsp_zero_out      (rsp_zero_out),
      .rsp_negative_out  (rsp_negative_out),
      .rsp_overflow_out  (rsp_overflow_out)
   );

endmodule
